// ===== src/hhec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhec_pkg
// Shared types and constants of the humidity hysteresis controller.
// ----------------------------------------------------------------------------
package hhec_pkg;

   localparam int unsigned HUM_W  = 10;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned IDX_W  = 2;
   localparam int unsigned CSR_W  = 32;

   // register indexes
   localparam logic [IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
   localparam logic [IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
   localparam logic [IDX_W-1:0] REG_EFFECT_TIMEOUT = 2'd2;
   localparam logic [IDX_W-1:0] REG_MIN_RISE       = 2'd3;

   // register reset values
   localparam logic [HUM_W-1:0]  LOW_THRESHOLD_RST  = 10'd500;
   localparam logic [HUM_W-1:0]  HIGH_THRESHOLD_RST = 10'd600;
   localparam logic [TIME_W-1:0] EFFECT_TIMEOUT_RST = 32'd600000;
   localparam logic [HUM_W-1:0]  MIN_RISE_RST       = 10'd20;

   // switch event codes
   localparam logic [1:0] EVT_NONE = 2'd0;
   localparam logic [1:0] EVT_ON   = 2'd1;
   localparam logic [1:0] EVT_OFF  = 2'd2;

   typedef struct packed {
      logic [HUM_W-1:0]  low_threshold;
      logic [HUM_W-1:0]  high_threshold;
      logic [TIME_W-1:0] effect_timeout_ms;
      logic [HUM_W-1:0]  min_rise;
   } cfg_type;

   typedef struct packed {
      logic       humidifier_on;
      logic       ineffective;
      logic [1:0] switch_event;
   } result_type;

endpackage
`default_nettype wire

// ===== src/hhec_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhec_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module hhec_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [hhec_pkg::IDX_W-1:0] csr_index,
   input  wire logic [hhec_pkg::CSR_W-1:0] csr_wdata,
   output hhec_pkg::cfg_type              cfg
);

   hhec_pkg::cfg_type cfg_ff;
   hhec_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            hhec_pkg::REG_LOW_THRESHOLD:
               cfg_in.low_threshold = csr_wdata[hhec_pkg::HUM_W-1:0];
            hhec_pkg::REG_HIGH_THRESHOLD:
               cfg_in.high_threshold = csr_wdata[hhec_pkg::HUM_W-1:0];
            hhec_pkg::REG_EFFECT_TIMEOUT:
               cfg_in.effect_timeout_ms = csr_wdata[hhec_pkg::TIME_W-1:0];
            hhec_pkg::REG_MIN_RISE:
               cfg_in.min_rise = csr_wdata[hhec_pkg::HUM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold     <= hhec_pkg::LOW_THRESHOLD_RST;
         cfg_ff.high_threshold    <= hhec_pkg::HIGH_THRESHOLD_RST;
         cfg_ff.effect_timeout_ms <= hhec_pkg::EFFECT_TIMEOUT_RST;
         cfg_ff.min_rise          <= hhec_pkg::MIN_RISE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== src/hhec_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhec_core
// Hysteresis switch and effect window; state advances once per sample.
// ----------------------------------------------------------------------------
module hhec_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [hhec_pkg::HUM_W-1:0]  humidity,
   input  wire logic [hhec_pkg::TIME_W-1:0] time_ms,
   input  wire hhec_pkg::cfg_type           cfg,
   output hhec_pkg::result_type             result
);

   logic                        running_ff,  running_in;
   logic                        wvalid_ff,   wvalid_in;
   logic [hhec_pkg::TIME_W-1:0] wstart_ff,   wstart_in;
   logic [hhec_pkg::HUM_W-1:0]  shum_ff,     shum_in;
   logic                        fault_ff,    fault_in;

   logic                        turn_on, turn_off;
   logic                        run_a, wv_a, fault_a;
   logic [hhec_pkg::TIME_W-1:0] ws_a;
   logic [hhec_pkg::HUM_W-1:0]  sh_a;
   logic [hhec_pkg::TIME_W-1:0] age;
   logic signed [hhec_pkg::HUM_W:0] rise;
   logic                        expired;

   always_comb begin
      // switch on below low threshold
      turn_on = (humidity < cfg.low_threshold) && !running_ff;
      run_a   = running_ff | turn_on;
      wv_a    = turn_on ? 1'b1     : wvalid_ff;
      ws_a    = turn_on ? time_ms  : wstart_ff;
      sh_a    = turn_on ? humidity : shum_ff;
      fault_a = turn_on ? 1'b0     : fault_ff;

      // switch off above high threshold (may undo the switch-on)
      turn_off   = (humidity > cfg.high_threshold) && run_a;
      running_in = run_a & ~turn_off;
      wvalid_in  = wv_a  & ~turn_off;
      fault_in   = fault_a & ~turn_off;
      wstart_in  = ws_a;
      shum_in    = sh_a;

      // window age wraps modulo 2^32
      age     = time_ms - ws_a;
      expired = running_in && wvalid_in && (age >= cfg.effect_timeout_ms);
      rise    = $signed({1'b0, humidity}) - $signed({1'b0, sh_a});
      if (expired) begin
         fault_in  = rise < $signed({1'b0, cfg.min_rise});
         wstart_in = time_ms;
         shum_in   = humidity;
      end

      result.humidifier_on = running_in;
      result.ineffective   = fault_in;
      if (running_in && !running_ff) begin
         result.switch_event = hhec_pkg::EVT_ON;
      end else if (!running_in && running_ff) begin
         result.switch_event = hhec_pkg::EVT_OFF;
      end else begin
         result.switch_event = hhec_pkg::EVT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         wvalid_ff  <= 1'b0;
         wstart_ff  <= '0;
         shum_ff    <= '0;
         fault_ff   <= 1'b0;
      end else if (step) begin
         running_ff <= running_in;
         wvalid_ff  <= wvalid_in;
         wstart_ff  <= wstart_in;
         shum_ff    <= shum_in;
         fault_ff   <= fault_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/humidity_hysteresis_with_effect_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_hysteresis_with_effect_check
// Bang-bang humidifier control with a humidity-rise watchdog.
// ----------------------------------------------------------------------------
// Each sample (humidity in tenths of a percent, millisecond timestamp) gives
// exactly one result. The humidifier switches on when a sample is below
// low_threshold and off when above high_threshold. While on, a watch window
// runs; once it is effect_timeout_ms old (modulo 2^32) the ineffective flag
// is set if humidity rose by less than min_rise, and the window restarts on
// that sample. Throughput is one transfer per clock while the rsp side does
// not stall: a sample is captured in an input register, and the whole step
// is evaluated combinationally from there into the result register, which
// drives rsp_tvalid. The rsp side may stall freely; req_tready drops only
// when both registers are full and rsp_tready is low. Configuration is
// written via csr_*; the user is to write it only while the block is idle,
// which the block itself does not enforce. Register indexes:
// 0 low_threshold, 1 high_threshold, 2 effect_timeout_ms, 3 min_rise.
// ----------------------------------------------------------------------------
module humidity_hysteresis_with_effect_check (
   input  wire logic        clock,
   input  wire logic        reset,
   // sample channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,   // [9:0] humidity, [41:10] time_ms, zero pad
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [0] humidifier_on, [1] ineffective,
                                         // [3:2] switch_event, zero pad
   // configuration
   input  wire logic                       csr_we,
   input  wire logic [hhec_pkg::IDX_W-1:0] csr_index,
   input  wire logic [hhec_pkg::CSR_W-1:0] csr_wdata
);

   hhec_pkg::cfg_type    cfg;
   hhec_pkg::result_type result;

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [hhec_pkg::HUM_W-1:0]  in_hum_ff;
   logic [hhec_pkg::TIME_W-1:0] in_time_ff;

   // result register
   logic                        out_valid_ff, out_valid_in;
   hhec_pkg::result_type        out_res_ff;

   logic out_free;
   logic step;
   logic req_xfer;

   // the result register frees up when empty or being taken this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_hum_ff  <= req_tdata[hhec_pkg::HUM_W-1:0];
         in_time_ff <= req_tdata[hhec_pkg::HUM_W +: hhec_pkg::TIME_W];
      end
      if (step) begin
         out_res_ff <= result;
      end
   end

   hhec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // controller state moves on exactly when a sample passes into the result
   hhec_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .humidity (in_hum_ff),
      .time_ms  (in_time_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_res_ff.switch_event,
                        out_res_ff.ineffective, out_res_ff.humidifier_on};

endmodule
`default_nettype wire

// ===== tb/humidity_hysteresis_with_effect_check_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_hysteresis_with_effect_check_test
// Self-checking bench for the humidifier hysteresis controller.
// ----------------------------------------------------------------------------
// Humidity samples are streamed in on req_*, and every result on rsp_* is
// checked field by field against an in-bench model of the controller: on/off
// hysteresis, switch events and the rise watchdog with 32-bit wrapping time.
// A short directed run covers threshold edges, time wrap, crossed thresholds,
// zero timeout and extreme register values. Random phases follow under
// several register settings, with humidity random walks that cycle the
// controller, plus noise samples and odd time steps.
// ----------------------------------------------------------------------------
module humidity_hysteresis_with_effect_check_test;

   // Tracks the controller state and holds the results still owed by the
   // block, oldest first.
   class humidity_scoreboard;
      hhec_pkg::cfg_type                cfg;
      bit                               heating;
      bit                               window_open;
      logic [hhec_pkg::TIME_W-1:0]      window_t0;
      logic [hhec_pkg::HUM_W-1:0]       window_hum;
      bit                               fault;
      hhec_pkg::result_type             owed_results[$];
      int                               errors;

      function new();
         cfg.low_threshold     = hhec_pkg::LOW_THRESHOLD_RST;
         cfg.high_threshold    = hhec_pkg::HIGH_THRESHOLD_RST;
         cfg.effect_timeout_ms = hhec_pkg::EFFECT_TIMEOUT_RST;
         cfg.min_rise          = hhec_pkg::MIN_RISE_RST;
         heating     = 1'b0;
         window_open = 1'b0;
         window_t0   = '0;
         window_hum  = '0;
         fault       = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [hhec_pkg::IDX_W-1:0] idx,
                              logic [hhec_pkg::CSR_W-1:0] value);
         case (idx)
            hhec_pkg::REG_LOW_THRESHOLD:
               cfg.low_threshold     = value[hhec_pkg::HUM_W-1:0];
            hhec_pkg::REG_HIGH_THRESHOLD:
               cfg.high_threshold    = value[hhec_pkg::HUM_W-1:0];
            hhec_pkg::REG_EFFECT_TIMEOUT:
               cfg.effect_timeout_ms = value[hhec_pkg::TIME_W-1:0];
            hhec_pkg::REG_MIN_RISE:
               cfg.min_rise          = value[hhec_pkg::HUM_W-1:0];
            default: ;
         endcase
      endfunction

      // one accepted sample -> one owed result
      function void note_sample(logic [hhec_pkg::HUM_W-1:0] hum,
                                logic [hhec_pkg::TIME_W-1:0] now);
         hhec_pkg::result_type        r;
         bit                          was_on;
         logic [hhec_pkg::TIME_W-1:0] age;
         int                          rise;
         was_on = heating;
         if (hum < cfg.low_threshold && !heating) begin
            heating     = 1'b1;
            window_open = 1'b1;
            window_t0   = now;
            window_hum  = hum;
            fault       = 1'b0;
         end
         if (hum > cfg.high_threshold && heating) begin
            heating     = 1'b0;
            window_open = 1'b0;
            fault       = 1'b0;
         end
         if (heating && window_open) begin
            age = now - window_t0;
            if (age >= cfg.effect_timeout_ms) begin
               rise       = int'(hum) - int'(window_hum);
               fault      = rise < int'(cfg.min_rise);
               window_t0  = now;
               window_hum = hum;
            end
         end
         r.humidifier_on = heating;
         r.ineffective   = fault;
         if (heating && !was_on)
            r.switch_event = hhec_pkg::EVT_ON;
         else if (!heating && was_on)
            r.switch_event = hhec_pkg::EVT_OFF;
         else
            r.switch_event = hhec_pkg::EVT_NONE;
         owed_results.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         if (errors <= 100)
            $display("%0t: mismatch on %s, got %0d, want %0d", $time, what, got, want);
      endtask

      task check_result(logic [7:0] data);
         hhec_pkg::result_type want;
         if (owed_results.size() == 0) begin
            report_mismatch("result with nothing owed", int'(data), 0);
            return;
         end
         want = owed_results.pop_front();
         if (data[0] !== want.humidifier_on)
            report_mismatch("humidifier_on", int'(data[0]), int'(want.humidifier_on));
         if (data[1] !== want.ineffective)
            report_mismatch("ineffective", int'(data[1]), int'(want.ineffective));
         if (data[3:2] !== want.switch_event)
            report_mismatch("switch_event", int'(data[3:2]), int'(want.switch_event));
      endtask

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [47:0]                      req_tdata  = '0;  // [9:0] humidity, [41:10] time_ms
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [7:0]                       rsp_tdata;        // [0] humidifier_on, [1] ineffective,
                                                       // [3:2] switch_event, zero pad
   logic                             csr_we     = 1'b0;
   logic [hhec_pkg::IDX_W-1:0]       csr_index  = '0;
   logic [hhec_pkg::CSR_W-1:0]       csr_wdata  = '0;

   humidity_scoreboard sb;

   // idling switches for either side; both off gives a gap-free stretch
   bit                               sender_gaps     = 1'b1;
   bit                               receiver_stalls = 1'b1;
   int                               walk_hum;
   logic [hhec_pkg::TIME_W-1:0]      now_ms;

   humidity_hysteresis_with_effect_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: stalls about 36 % of cycles when enabled.
   always @(negedge clock) begin
      rsp_tready <= receiver_stalls ? ($urandom_range(99) >= 36) : 1'b1;
   end

   // Monitor at the rising edge. Results are checked before the new sample is
   // noted, since a result can never stem from a transfer on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata[9:0], req_tdata[41:10]);
      end
   end

   // All driver tasks are entered and left at a falling edge.
   task automatic write_csr(input logic [hhec_pkg::IDX_W-1:0] idx,
                            input logic [hhec_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      sb.write_reg(idx, value);
   endtask

   // noisy: junk above bit 9 of the 10-bit registers, which must be ignored
   task automatic set_config(input int low, input int high, input logic [31:0] timeout,
                             input int rise, input bit noisy);
      logic [31:0] pad;
      pad = noisy ? ($urandom() & 32'hFFFF_FC00) : 32'd0;
      write_csr(hhec_pkg::REG_LOW_THRESHOLD, pad | 32'(low));
      write_csr(hhec_pkg::REG_HIGH_THRESHOLD, pad | 32'(high));
      write_csr(hhec_pkg::REG_EFFECT_TIMEOUT, timeout);
      write_csr(hhec_pkg::REG_MIN_RISE, pad | 32'(rise));
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic [hhec_pkg::HUM_W-1:0] hum,
                              input logic [hhec_pkg::TIME_W-1:0] at_ms);
      while (sender_gaps && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, at_ms, hum};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // wait for every owed result, then idle to let the two-stage pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // time step: up to twice the window length, or a quarter of it for long windows, with edge cases mixed in
   function automatic logic [31:0] next_gap(input logic [31:0] timeout);
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)  return timeout;
      if (pick < 10) return timeout - 1;
      if (pick < 15) return $urandom();
      if (pick < 18) return 32'd0;
      if (timeout <= 100000) return $urandom_range(2 * timeout + 2, 0);
      return $urandom_range(timeout / 4, 0);
   endfunction

   // Humidity walks upward while heating and downward otherwise, so the
   // controller keeps cycling; one sample in ten is uniform noise.
   task automatic random_samples(input int count);
      int                         w;
      logic [hhec_pkg::HUM_W-1:0] hum;
      repeat (count) begin
         if ($urandom_range(99) < 10) begin
            hum = 10'($urandom_range(1023));
         end else begin
            w = walk_hum + $urandom_range(60) - (sb.heating ? 20 : 40);
            if (w < 0) w = 0;
            if (w > 1023) w = 1023;
            walk_hum = w;
            hum = w[hhec_pkg::HUM_W-1:0];
         end
         now_ms = now_ms + next_gap(sb.cfg.effect_timeout_ms);
         send_sample(hum, now_ms);
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: low 500, high 600, window 600000 ms, rise 20
      send_sample(10'd600, 32'd0);              // off, at high edge
      send_sample(10'd500, 32'd10);             // equal to low: stays off
      send_sample(10'd499, 32'd100);            // on, window opens
      send_sample(10'd600, 32'd200);            // equal to high: stays on
      send_sample(10'd499, 32'd600099);         // one ms short of the window
      send_sample(10'd515, 32'd600100);         // window closes, rise 16: flagged
      send_sample(10'd540, 32'd1200100);        // rise 25: cleared
      send_sample(10'd480, 32'd1800100);        // fall counts as short rise
      send_sample(10'd601, 32'd1800101);        // off, flag cleared
      send_sample(10'd0, 32'hFFFF_FF00);
      send_sample(10'd1023, 32'hFFFF_FFFF);
      send_sample(10'd400, 32'hFFFF_FFF0);      // window opens just before wrap
      send_sample(10'd430, 32'd600000);         // age across the wrap
      send_sample(10'd1023, 32'd600001);
      drain_results();

      // crossed thresholds: one sample may switch on and off at once
      set_config(700, 300, 32'd600000, 20, 1'b0);
      send_sample(10'd500, 32'd10);
      send_sample(10'd200, 32'd20);
      send_sample(10'd500, 32'd30);
      drain_results();

      // zero timeout: every sample while on closes a window
      set_config(500, 600, 32'd0, 20, 1'b0);
      send_sample(10'd400, 32'd40);
      send_sample(10'd420, 32'd40);
      send_sample(10'd410, 32'd41);
      send_sample(10'd601, 32'd42);
      drain_results();

      // top of the 10-bit registers, one ms window, no required rise
      set_config(1023, 1023, 32'd1, 0, 1'b0);
      send_sample(10'd1023, 32'd50);
      send_sample(10'd1022, 32'd51);
      send_sample(10'd1023, 32'd52);
      send_sample(10'd0, 32'd52);
      drain_results();

      now_ms = $urandom();
      for (int phase = 0; phase < 8; phase++) begin
         sender_gaps     = (phase != 1);
         receiver_stalls = (phase != 1);
         case (phase)
            0: set_config(500, 600, 32'd40, 20, 1'b0);
            1: set_config(300, 700, 32'd200, 50, 1'b0);
            2: set_config(1023, 1023, 32'd0, 1023, 1'b0);
            3: set_config(1000, 0, 32'd5, 0, 1'b0);
            4: set_config(400, 650, 32'hFFFF_FFFF, 1023, 1'b0);
            5: set_config($urandom_range(1023), $urandom_range(1023),
                          $urandom_range(300), $urandom_range(1023), 1'b1);
            6: set_config($urandom_range(1023), $urandom_range(1023),
                          $urandom_range(300), $urandom_range(60), 1'b1);
            default: set_config(500, 600, 32'd600000, 20, 1'b0);
         endcase
         walk_hum = int'(sb.cfg.low_threshold);
         random_samples(230);
         drain_results();
      end

      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hhec_pkg.sv
src/hhec_csr.sv
src/hhec_core.sv
src/humidity_hysteresis_with_effect_check.sv
tb/humidity_hysteresis_with_effect_check_test.sv
